// ===== design/sffa_pkg.sv =====
// Shared types and constants of the scatter first-fit allocator.
// No dependencies; used by sffa_unit, sffa_regs and the top level.
package sffa_pkg;

  localparam int WORD_W     = 16;
  localparam int RIDX_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_REGIONS = 4;

  // register index: bit 2 picks base over size, bits 1:0 pick the region
  localparam logic CFG_KIND_SIZE = 1'b0;
  localparam logic CFG_KIND_BASE = 1'b1;

  typedef struct packed {
    logic              nz;
    logic              ge;
    logic [WORD_W-1:0] take;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] free_new;
  } unit_res_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [WORD_W-1:0] free;
  } free_upd_t;

endpackage

// ===== design/sffa_unit.sv =====
// Shared compare/subtract unit: checks one region against the remaining request.
// Depends on sffa_pkg.
module sffa_unit (
  input  logic [sffa_pkg::WORD_W-1:0] free_i,
  input  logic [sffa_pkg::WORD_W-1:0] rest_i,
  output sffa_pkg::unit_res_t         res_o
);

  logic ge;
  logic [sffa_pkg::WORD_W-1:0] take;

  assign ge   = (free_i >= rest_i);
  assign take = ge ? rest_i : free_i;

  assign res_o.nz       = (free_i != '0);
  assign res_o.ge       = ge;
  assign res_o.take     = take;
  assign res_o.left     = rest_i - take;
  assign res_o.free_new = free_i - take;

endmodule

// ===== design/sffa_regs.sv =====
// Region register file: size, base and free words per region, config writes.
// Depends on sffa_pkg.
module sffa_regs #(
  parameter int NUM_REGIONS = 4,
  parameter int ADDR_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sffa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sffa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  sffa_pkg::free_upd_t             upd_i,
  input  logic [sffa_pkg::SLOT_W-1:0]     rd_idx_i,
  output logic [sffa_pkg::WORD_W-1:0]     rd_free_o,
  output logic [sffa_pkg::WORD_W-1:0]     rd_start_o,
  output logic [NUM_REGIONS-1:0]          nz_o
);

  localparam int IDX_W     = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int SPAN_BITS = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam logic [sffa_pkg::WORD_W-1:0] SPAN_MASK =
    sffa_pkg::WORD_W'((32'd1 << SPAN_BITS) - 32'd1);

  logic [sffa_pkg::WORD_W-1:0] size_q [NUM_REGIONS];
  logic [sffa_pkg::WORD_W-1:0] base_q [NUM_REGIONS];
  logic [sffa_pkg::WORD_W-1:0] free_q [NUM_REGIONS];
  logic [IDX_W-1:0] rd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        size_q[i] <= '0;
        base_q[i] <= '0;
        free_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        if (cfg_we_i && (i < sffa_pkg::CFG_REGIONS) && (int'(cfg_idx_i[1:0]) == i)) begin
          if (cfg_idx_i[2] == sffa_pkg::CFG_KIND_SIZE) begin
            size_q[i] <= cfg_wdata_i;
            free_q[i] <= cfg_wdata_i;
          end else begin
            base_q[i] <= cfg_wdata_i;
          end
        end else if (upd_i.en && (int'(upd_i.idx) == i)) begin
          free_q[i] <= upd_i.free;
        end
      end
    end
  end

  assign rd_idx     = rd_idx_i[IDX_W-1:0];
  assign rd_free_o  = free_q[rd_idx];
  assign rd_start_o = (base_q[rd_idx] + size_q[rd_idx] - free_q[rd_idx]) & SPAN_MASK;

  always_comb begin
    for (int i = 0; i < NUM_REGIONS; i++) begin
      nz_o[i] = (free_q[i] != '0);
    end
  end

endmodule

// ===== design/scatter_first_fit_allocator.sv =====
// Top level of the scatter first-fit allocator: sequencer and output register.
// Depends on sffa_pkg, sffa_unit and sffa_regs.
// Unless the output stalls, a request first scans the regions one per cycle
// for a whole fit, then, if none holds it, scans them again one per cycle
// splitting the request into spans; one compare/subtract unit serves every
// step. The input is not ready until the request's last word has been loaded
// into the output register. Size writes reload the region's free space;
// write configuration only while idle.
module scatter_first_fit_allocator #(
  parameter int NUM_REGIONS = 4,
  parameter int ADDR_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sffa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sffa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // request_size
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // region_index, span_start, span_length
  output logic                            m_axis_tlast,   // last_span
  output logic                            m_axis_tuser    // alloc_status
);

  localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGIONS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIT   = 2'd1;
  localparam logic [1:0] S_SPLIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [sffa_pkg::WORD_W-1:0] rest_q, rest_d;

  logic                          out_valid_q, out_valid_d;
  logic [sffa_pkg::RIDX_W-1:0]   out_ridx_q, out_ridx_d;
  logic [sffa_pkg::WORD_W-1:0]   out_start_q, out_start_d;
  logic [sffa_pkg::WORD_W-1:0]   out_len_q, out_len_d;
  logic                          out_last_q, out_last_d;
  logic                          out_stat_q, out_stat_d;

  logic [sffa_pkg::WORD_W-1:0] rd_free, rd_start;
  logic [NUM_REGIONS-1:0] nz_vec;
  logic any_nz, later_nz, ostall, split_last;
  sffa_pkg::unit_res_t res;
  sffa_pkg::free_upd_t upd;

  sffa_regs #(
    .NUM_REGIONS(NUM_REGIONS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .upd_i      (upd),
    .rd_idx_i   (sffa_pkg::SLOT_W'(idx_q)),
    .rd_free_o  (rd_free),
    .rd_start_o (rd_start),
    .nz_o       (nz_vec)
  );

  sffa_unit u_unit (
    .free_i(rd_free),
    .rest_i(rest_q),
    .res_o (res)
  );

  assign any_nz = |nz_vec;
  assign ostall = out_valid_q && !m_axis_tready;

  always_comb begin
    later_nz = 1'b0;
    for (int i = 0; i < NUM_REGIONS; i++) begin
      if (nz_vec[i] && (i > int'(idx_q))) later_nz = 1'b1;
    end
  end

  assign split_last = (res.left == '0) || !later_nz;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rest_d      = rest_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ridx_d  = out_ridx_q;
    out_start_d = out_start_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_stat_d  = out_stat_q;
    upd.en      = 1'b0;
    upd.idx     = sffa_pkg::SLOT_W'(idx_q);
    upd.free    = res.free_new;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          rest_d  = s_axis_tdata;
          idx_d   = '0;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        if (!ostall) begin
          if (!any_nz) begin
            out_valid_d = 1'b1;
            out_ridx_d  = '0;
            out_start_d = '0;
            out_len_d   = '0;
            out_last_d  = 1'b1;
            out_stat_d  = 1'b1;
            state_d     = S_IDLE;
          end else if (res.nz && res.ge) begin
            out_valid_d = 1'b1;
            out_ridx_d  = sffa_pkg::RIDX_W'(idx_q);
            out_start_d = rd_start;
            out_len_d   = rest_q;
            out_last_d  = 1'b1;
            out_stat_d  = 1'b0;
            upd.en      = 1'b1;
            state_d     = S_IDLE;
          end else if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            state_d = S_SPLIT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_SPLIT: begin
        if (!ostall) begin
          if (res.nz) begin
            out_valid_d = 1'b1;
            out_ridx_d  = sffa_pkg::RIDX_W'(idx_q);
            out_start_d = rd_start;
            out_len_d   = res.take;
            out_last_d  = split_last;
            out_stat_d  = split_last && (res.left != '0);
            upd.en      = 1'b1;
            rest_d      = res.left;
          end
          if ((res.nz && split_last) || idx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q      <= rest_d;
    out_ridx_q  <= out_ridx_d;
    out_start_q <= out_start_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    out_stat_q  <= out_stat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_len_q, out_start_q, out_ridx_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for scatter_first_fit_allocator: drives allocation requests with
// random gaps and stalls, predicts the spans of each accepted request and checks every word.
// Depends on sffa_pkg and the allocator RTL.
module testbench;

  localparam int NREG         = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * NREG + 8;

  typedef struct packed {
    logic [1:0]  region;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
    logic        status;
  } span_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [sffa_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [sffa_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  scatter_first_fit_allocator #(
    .NUM_REGIONS(NREG),
    .ADDR_BITS  (16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  logic [15:0] region_size [NREG];
  logic [15:0] region_base [NREG];
  logic [15:0] region_free [NREG];

  logic [15:0] pending_requests [$];
  span_t       expected_spans [$];

  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;
  int tx_idle_left  = 0;
  int rx_idle_left  = 0;
  int hold_left     = 0;
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_used = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] span_addr(int r);
    return region_base[r] + (region_size[r] - region_free[r]);
  endfunction

  function automatic void add_span(span_t s);
    expected_spans.insert(expected_spans.size(), s);
  endfunction

  function automatic void add_request(logic [15:0] req);
    pending_requests.insert(pending_requests.size(), req);
  endfunction

  function automatic void place_request(logic [15:0] need);
    span_t       spans [NREG];
    int          n;
    logic [15:0] placed;
    logic [15:0] rest;
    logic [15:0] take;
    n = 0;
    placed = '0;
    for (int r = 0; r < NREG; r++) begin
      if (region_free[r] != 0 && region_free[r] >= need) begin
        add_span('{2'(r), span_addr(r), need, 1'b1, 1'b0});
        region_free[r] -= need;
        return;
      end
    end
    for (int r = 0; r < NREG && placed < need; r++) begin
      if (region_free[r] != 0) begin
        rest = need - placed;
        take = (region_free[r] < rest) ? region_free[r] : rest;
        spans[n] = '{2'(r), span_addr(r), take, 1'b0, 1'b0};
        region_free[r] -= take;
        placed += take;
        n++;
      end
    end
    if (n == 0) begin
      add_span('{2'd0, 16'd0, 16'd0, 1'b1, 1'b1});
    end else begin
      spans[n-1].last = 1'b1;
      spans[n-1].status = (placed < need);
      for (int i = 0; i < n; i++) add_span(spans[i]);
    end
  endfunction

  // sender: hold an unaccepted word, else idle in bursts or advance the queue
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) place_request(s_axis_tdata);
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (tx_idle_left > 0) begin
        tx_idle_left--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && pending_requests.size() != 0 && $urandom_range(0, 7) == 0) begin
        tx_idle_left = $urandom_range(0, 5);
        s_axis_tvalid <= 1'b0;
      end else if (rst_ni && pending_requests.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_requests.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: one long hold on request, otherwise short random stalls
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_used) begin
      long_hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    span_t got;
    span_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tdata[33:18],
              m_axis_tlast, m_axis_tuser};
      if (expected_spans.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected word: region %0d start %h length %0d last %b status %b",
                   got.region, got.start, got.length, got.last, got.status);
        mismatch_cnt++;
      end else begin
        want = expected_spans.pop_front();
        if (got.region !== want.region || got.start !== want.start ||
            got.length !== want.length || got.last !== want.last ||
            got.status !== want.status) begin
          if (mismatch_cnt < 10)
            $display("mismatch: region %0d/%0d start %h/%h length %0d/%0d last %b/%b status %b/%b",
                     want.region, got.region, want.start, got.start, want.length, got.length,
                     want.last, got.last, want.status, got.status);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic kind, int r, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= {kind, 2'(r)};
    cfg_wdata_i <= value;
    if (kind == sffa_pkg::CFG_KIND_SIZE) begin
      region_size[r] = value;
      region_free[r] = value;
    end else begin
      region_base[r] = value;
    end
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_spans.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_request();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, 250));
    endcase
  endfunction

  initial begin
    for (int r = 0; r < NREG; r++) begin
      region_size[r] = '0;
      region_base[r] = '0;
      region_free[r] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing configured: every request fails empty
    add_request(16'd0);
    add_request(16'hFFFF);
    wait_idle();

    // mixed regions with an unused one and wrapping bases
    write_reg(sffa_pkg::CFG_KIND_SIZE, 0, 16'd100);
    write_reg(sffa_pkg::CFG_KIND_SIZE, 1, 16'd0);
    write_reg(sffa_pkg::CFG_KIND_SIZE, 2, 16'd50);
    write_reg(sffa_pkg::CFG_KIND_SIZE, 3, 16'hFFFF);
    write_reg(sffa_pkg::CFG_KIND_BASE, 0, 16'h0000);
    write_reg(sffa_pkg::CFG_KIND_BASE, 1, 16'h1234);
    write_reg(sffa_pkg::CFG_KIND_BASE, 2, 16'hFFF0);
    write_reg(sffa_pkg::CFG_KIND_BASE, 3, 16'hFFFF);
    end_writes();
    pending_requests = '{16'd0, 16'd10, 16'd95, 16'd40, 16'hFFFF, 16'd1, 16'd10, 16'd3};
    wait_idle();

    // full-size regions at the top address
    for (int r = 0; r < NREG; r++) begin
      write_reg(sffa_pkg::CFG_KIND_SIZE, r, 16'hFFFF);
      write_reg(sffa_pkg::CFG_KIND_BASE, r, 16'hFFFF);
    end
    end_writes();
    pending_requests = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
    wait_idle();
    write_reg(sffa_pkg::CFG_KIND_SIZE, 1, 16'd1);
    end_writes();
    add_request(16'd2);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      for (int r = 0; r < NREG; r++)
        if ($urandom_range(0, 2) != 0) write_reg(sffa_pkg::CFG_KIND_SIZE, r, pick_size());
      for (int r = 0; r < NREG; r++)
        if ($urandom_range(0, 1) != 0) write_reg(sffa_pkg::CFG_KIND_BASE, r, 16'($urandom()));
      end_writes();
      if (ph == 2) long_hold_req = 1'b1;
      for (int i = 0; i < 25; i++) add_request(pick_request());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_spans.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
